// ===== sv/swm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

    localparam int SAMPLE_W       = 32;
    localparam int LEN_W          = 7;
    localparam int WINDOW_MAX_DEF = 64;
    localparam logic [LEN_W-1:0] LEN_RESET = 7'd3;

    // per-cell flags handed to the neighbors
    typedef struct packed {
        logic valid;     // cell holds a sample
        logic gt;        // cell is empty or its sample is above the incoming one
        logic del_seen;  // the expiring sample sits in this cell or below it
    } cell_flags_t;

endpackage

`default_nettype wire

// ===== sv/swm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface swm_sample_if;
    logic                          valid;
    logic                          ready;
    logic [swm_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface swm_median_if;
    logic                          valid;
    logic                          ready;
    logic [swm_pkg::SAMPLE_W-1:0]  median_value;

    modport source (output valid, output median_value, input ready);
    modport sink   (input valid, input median_value, output ready);
endinterface

interface swm_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [swm_pkg::LEN_W-1:0]     window_length;

    modport source (output valid, output window_length, input ready);
    modport sink   (input valid, input window_length, output ready);
endinterface

`default_nettype wire

// ===== sv/sliding_window_median.sv =====
`timescale 1ns / 1ps
`default_nettype none

// sliding window median filter
// in_ch carries one unsigned sample per transfer, out_ch one lower median per
// transfer, cfg_ch writes the window length k (0 acts as 1, above WINDOW_MAX
// saturates). a config write also empties the window; write only while idle.
// the window is a row of WINDOW_MAX cells kept in ascending order; each used
// cell holds a sample and its age. each accepted sample evicts the cell whose
// age is k-1 and is inserted in order in the same cycle, so one sample a
// cycle is taken while out_ch keeps up; the cell row updates on each sample.
// the first k-1 samples after reset or a config write give no result; every
// later sample gives one, the cell at sorted position (k-1)/2.
// a result goes from the cell row into the output register driving out_ch.
// reset empties the window and sets k to 3.
// when out_ch stalls, one more result waits in the cell row; in_ch then
// drops ready until the output register frees up, so nothing is lost.
module sliding_window_median #(
    parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    swm_sample_if.sink    in_ch,
    swm_median_if.source  out_ch,
    swm_cfg_if.sink       cfg_ch
);
    import swm_pkg::*;

    localparam int AGE_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);

    // configuration
    logic [LEN_W-1:0]    wlen_reg;
    logic [CNT_W-1:0]    k_eff;
    logic [AGE_W-1:0]    k_m1;
    logic [AGE_W-1:0]    mid;
    logic                cfg_wr;

    // flow control
    logic                in_xfer;
    logic                produce;
    logic                move;
    logic                pend_reg;
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] median_reg;
    logic [CNT_W-1:0]    fill_reg;
    logic [CNT_W-1:0]    fill_inc;

    // cell row
    cell_flags_t         cell_flags [WINDOW_MAX];
    logic [SAMPLE_W-1:0] cell_value [WINDOW_MAX];
    logic [AGE_W-1:0]    cell_age   [WINDOW_MAX];
    logic [WINDOW_MAX-1:0] valid_vec;

    assign cfg_ch.ready = 1'b1;
    assign cfg_wr       = cfg_ch.valid;

    always_comb
    begin
        if (wlen_reg == '0)
        begin
            k_eff = CNT_W'(1);
        end
        else if (32'(wlen_reg) > 32'(WINDOW_MAX))
        begin
            k_eff = CNT_W'(WINDOW_MAX);
        end
        else
        begin
            k_eff = CNT_W'(wlen_reg);
        end
    end

    assign k_m1 = AGE_W'(k_eff - 1'b1);
    assign mid  = k_m1 >> 1;

    // a waiting result moves to the output register when it is free
    assign move        = pend_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !pend_reg || move;
    assign in_xfer     = in_ch.valid && in_ch.ready;
    assign fill_inc    = CNT_W'(fill_reg + 1'b1);
    assign produce     = (fill_reg == k_eff) || (fill_inc == k_eff);

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_MAX; gi++)
        begin : g_cell
            cell_flags_t         lf;
            cell_flags_t         rf;
            logic [SAMPLE_W-1:0] lv;
            logic [SAMPLE_W-1:0] rv;
            logic [AGE_W-1:0]    la;
            logic [AGE_W-1:0]    ra;

            // bottom edge never shifts up, top edge looks like an empty cell
            if (gi == 0)
            begin : g_lo
                assign lf = '{valid: 1'b0, gt: 1'b0, del_seen: 1'b0};
                assign lv = '0;
                assign la = '0;
            end
            else
            begin : g_lo
                assign lf = cell_flags[gi-1];
                assign lv = cell_value[gi-1];
                assign la = cell_age[gi-1];
            end

            if (gi == WINDOW_MAX - 1)
            begin : g_hi
                assign rf = '{valid: 1'b0, gt: 1'b1, del_seen: 1'b0};
                assign rv = '0;
                assign ra = '0;
            end
            else
            begin : g_hi
                assign rf = cell_flags[gi+1];
                assign rv = cell_value[gi+1];
                assign ra = cell_age[gi+1];
            end

            swm_cell #(
                .AGE_W (AGE_W)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .load        (in_xfer),
                .clear       (cfg_wr),
                .sample      (in_ch.sample),
                .k_m1        (k_m1),
                .left_flags  (lf),
                .left_value  (lv),
                .left_age    (la),
                .right_flags (rf),
                .right_value (rv),
                .right_age   (ra),
                .flags       (cell_flags[gi]),
                .value       (cell_value[gi]),
                .age         (cell_age[gi])
            );

            assign valid_vec[gi] = cell_flags[gi].valid;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg      <= LEN_RESET;
            fill_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                wlen_reg <= cfg_ch.window_length;
                fill_reg <= '0;
            end
            else if (in_xfer && (fill_reg != k_eff))
            begin
                fill_reg <= fill_inc;
            end

            if (in_xfer)
            begin
                pend_reg <= produce;
            end
            else if (move)
            begin
                pend_reg <= 1'b0;
            end

            if (move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // median taken from the row once the sample has settled in
    always_ff @(posedge clk)
    begin
        if (move)
        begin
            median_reg <= cell_value[mid];
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.median_value = median_reg;

    // occupied cells always match the fill count
    a_fill_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(fill_reg))
        else $error("cell occupancy differs from fill count");

    // occupied cells form a contiguous run from the bottom
    a_cells_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + 1'b1)) == '0)
        else $error("gap in occupied cells");

    a_fill_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= k_eff)
        else $error("fill count above window length");

    // a waiting result reaches the output on the next edge once it is free
    a_pending_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && (!out_valid_reg || out_ch.ready)) |=> out_valid_reg)
        else $error("waiting result not forwarded");

endmodule

`default_nettype wire

// ===== sv/swm_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module swm_cell #(
    parameter int AGE_W = 6
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         load,
    input  wire logic                         clear,
    input  wire logic [swm_pkg::SAMPLE_W-1:0] sample,
    input  wire logic [AGE_W-1:0]             k_m1,
    input  wire swm_pkg::cell_flags_t         left_flags,
    input  wire logic [swm_pkg::SAMPLE_W-1:0] left_value,
    input  wire logic [AGE_W-1:0]             left_age,
    input  wire swm_pkg::cell_flags_t         right_flags,
    input  wire logic [swm_pkg::SAMPLE_W-1:0] right_value,
    input  wire logic [AGE_W-1:0]             right_age,
    output swm_pkg::cell_flags_t              flags,
    output logic [swm_pkg::SAMPLE_W-1:0]      value,
    output logic [AGE_W-1:0]                  age
);
    import swm_pkg::*;

    logic                valid_reg;
    logic                valid_next;
    logic [SAMPLE_W-1:0] value_reg;
    logic [SAMPLE_W-1:0] value_next;
    logic [AGE_W-1:0]    age_reg;
    logic [AGE_W-1:0]    age_next;
    logic                del_self;
    logic                gt_self;

    assign del_self = valid_reg && (age_reg == k_m1);
    assign gt_self  = !valid_reg || (value_reg > sample);

    assign flags.valid    = valid_reg;
    assign flags.gt       = gt_self;
    assign flags.del_seen = left_flags.del_seen || del_self;
    assign value          = value_reg;
    assign age            = age_reg;

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        age_next   = AGE_W'(age_reg + 1'b1);
        if (del_self)
        begin
            // expiring cell: filled from the left, by the new sample, or from the right
            if (left_flags.gt)
            begin
                valid_next = left_flags.valid;
                value_next = left_value;
                age_next   = AGE_W'(left_age + 1'b1);
            end
            else if (right_flags.gt)
            begin
                valid_next = 1'b1;
                value_next = sample;
                age_next   = '0;
            end
            else
            begin
                valid_next = right_flags.valid;
                value_next = right_value;
                age_next   = AGE_W'(right_age + 1'b1);
            end
        end
        else if (left_flags.del_seen)
        begin
            // above the hole: smaller samples slide down
            if (!gt_self)
            begin
                if (right_flags.gt)
                begin
                    valid_next = 1'b1;
                    value_next = sample;
                    age_next   = '0;
                end
                else
                begin
                    valid_next = right_flags.valid;
                    value_next = right_value;
                    age_next   = AGE_W'(right_age + 1'b1);
                end
            end
        end
        else if (gt_self)
        begin
            // below the hole or no hole: larger samples slide up
            if (left_flags.gt)
            begin
                valid_next = left_flags.valid;
                value_next = left_value;
                age_next   = AGE_W'(left_age + 1'b1);
            end
            else
            begin
                valid_next = 1'b1;
                value_next = sample;
                age_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= value_next;
            age_reg   <= age_next;
        end
    end

endmodule

`default_nettype wire

// ===== dv/swm_median_checker.sv =====
`timescale 1ns / 1ps

module swm_median_checker #(
    parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    swm_sample_if  in_ch,
    swm_median_if  out_ch,
    swm_cfg_if     cfg_ch,
    output int     mismatches,
    output int     medians_due
);

    typedef logic [swm_pkg::SAMPLE_W-1:0] sample_t;

    logic [swm_pkg::LEN_W-1:0] win_len;
    sample_t                   ring[WINDOW_MAX];
    sample_t                   ordered[WINDOW_MAX];
    int unsigned               held;
    int unsigned               oldest;
    sample_t                   median_q[$];
    sample_t                   want;

    // window length in use: zero acts as one, large values saturate
    function automatic int unsigned span();
        if (win_len == 0)
        begin
            return 1;
        end
        if (win_len > WINDOW_MAX)
        begin
            return WINDOW_MAX;
        end
        return int'(win_len);
    endfunction

    task automatic place_sorted(input int unsigned n, input sample_t v);
        int unsigned i;
        i = n;
        while (i > 0 && ordered[i-1] > v)
        begin
            ordered[i] = ordered[i-1];
            i--;
        end
        ordered[i] = v;
    endtask

    task automatic take_sample(input sample_t s);
        int unsigned k;
        int unsigned pos;
        int unsigned slot;
        sample_t     gone;
        k = span();
        if (held > k || oldest >= k)
        begin
            held   = 0;
            oldest = 0;
        end
        if (held == k)
        begin
            // drop the expiring sample, then slot the new one in
            gone = ring[oldest];
            pos  = k - 1;
            for (int unsigned i = 0; i < k; i++)
            begin
                if (ordered[i] == gone)
                begin
                    pos = i;
                    break;
                end
            end
            for (int unsigned i = pos; i + 1 < k; i++)
            begin
                ordered[i] = ordered[i+1];
            end
            place_sorted(k - 1, s);
            ring[oldest] = s;
            oldest       = (oldest + 1) % k;
        end
        else
        begin
            slot       = (oldest + held) % k;
            ring[slot] = s;
            place_sorted(held, s);
            held++;
        end
        if (held == k)
        begin
            median_q = {median_q, ordered[(k - 1) / 2]};
        end
    endtask

    task automatic report(input string msg);
        $display("%0t swm_median_checker: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_len    = swm_pkg::LEN_RESET;
            held       = 0;
            oldest     = 0;
            mismatches = 0;
            median_q.delete();
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                win_len = cfg_ch.window_length;
                held    = 0;
                oldest  = 0;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (median_q.size() == 0)
                begin
                    report($sformatf("median_value %h with no median pending",
                                     out_ch.median_value));
                end
                else
                begin
                    want = median_q.pop_front();
                    if (out_ch.median_value !== want)
                    begin
                        report($sformatf("median_value %h, predicted %h",
                                         out_ch.median_value, want));
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                take_sample(in_ch.sample);
            end
        end
        medians_due = median_q.size();
    end

endmodule

// ===== dv/tb_sliding_window_median.sv =====
`timescale 1ns / 1ps

module tb_sliding_window_median;

    // cycles with no transfer on any channel before the run is declared hung
    localparam int IDLE_LIMIT   = 3000;
    // deliberate receiver hold-off, long enough to back the block up
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 1800;

    logic clk;
    logic rst_n;

    swm_sample_if in_ch ();
    swm_median_if out_ch ();
    swm_cfg_if    cfg_ch ();

    int          mismatches;
    int          medians_due;
    int unsigned quiet_cycles;

    // long_hold is shared by sender and receiver: while the receiver holds
    // off on purpose, the sender keeps offering without gaps
    logic        long_hold;
    int unsigned steady_items;
    logic [31:0] last_sample;

    // window lengths visited first: the saturating 127 and 65, the exact
    // maximum, the zero case, small windows and the reset value
    logic [6:0]  corner_lens[8] = '{7'd127, 7'd64, 7'd2, 7'd65, 7'd4, 7'd1, 7'd0, 7'd3};
    // results after which the receiver starts a long hold-off
    int unsigned hold_marks[2]  = '{40, 900};

    // directed samples at the reset window of 3: extremes, msb patterns, and
    // runs of equal values so the expiring sample often equals the median
    logic [31:0] opening[15] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
        32'h0000_0005, 32'h0000_0005, 32'h0000_0005, 32'h0000_0005,
        32'h0000_0000, 32'h0000_0005, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'h0000_0005, 32'h0000_0001, 32'h0000_0001
    };

    sliding_window_median dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    swm_median_checker median_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_ch      (cfg_ch),
        .mismatches  (mismatches),
        .medians_due (medians_due)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // watchdog: any transfer on any channel counts as progress
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("%0t watchdog: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("tb_sliding_window_median: errors");
            $finish;
        end
    end

    // idle length: mostly none or short, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // sample mix: full random words, small values and repeats so that equal
    // entries pile up in the window, near-top values and single-bit words
    function automatic logic [31:0] pick_sample();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            return $urandom;
        end
        if (r < 65)
        begin
            return $urandom_range(0, 7);
        end
        if (r < 75)
        begin
            return 32'hFFFF_FFFF - $urandom_range(0, 3);
        end
        if (r < 92)
        begin
            return last_sample;
        end
        return 32'h1 << $urandom_range(0, 31);
    endfunction

    // one sample transfer; returns at the edge where it was taken
    task automatic send_sample(input logic [31:0] v);
        int unsigned gap;
        if (long_hold)
        begin
            gap = 0;
        end
        else if (steady_items > 0)
        begin
            steady_items--;
            gap = 0;
        end
        else if ($urandom_range(0, 39) == 0)
        begin
            // back-to-back stretch
            steady_items = $urandom_range(20, 80);
            gap          = 0;
        end
        else
        begin
            gap = idle_len();
        end
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.sample <= v;
        last_sample  = v;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    // stop offering and wait until every predicted median has come out,
    // then idle on so a trailing sample that makes no median can finish
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (medians_due != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // window length write, only from an idle block
    task automatic write_window(input logic [6:0] v);
        settle();
        cfg_ch.valid         <= 1'b1;
        cfg_ch.window_length <= v;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // receiver: random stalls, open stretches, and two long hold-offs that
    // start while the sender is offering so the block fills and stalls in_ch
    initial
    begin
        int unsigned stall_left;
        int unsigned open_left;
        int unsigned medians_taken;
        int unsigned holds_done;
        stall_left    = 0;
        open_left     = 0;
        medians_taken = 0;
        holds_done    = 0;
        long_hold     = 1'b0;
        out_ch.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                medians_taken++;
            end
            if (stall_left > 0)
            begin
                stall_left--;
            end
            else if (open_left > 0)
            begin
                open_left--;
            end
            else if (holds_done < 2 && medians_taken >= hold_marks[holds_done]
                     && in_ch.valid)
            begin
                stall_left = HOLD_CYCLES;
                long_hold  = 1'b1;
                holds_done++;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                stall_left = idle_len();
            end
            else if ($urandom_range(0, 24) == 0)
            begin
                open_left = $urandom_range(30, 120);
            end
            if (stall_left == 0)
            begin
                long_hold = 1'b0;
            end
            out_ch.ready <= (stall_left == 0);
        end
    end

    // stimulus and verdict
    initial
    begin
        int unsigned sent;
        int unsigned phase;
        int unsigned span_len;
        int unsigned phase_items;
        logic [6:0]  win;
        sent         = 0;
        phase        = 0;
        steady_items = 0;
        last_sample  = 32'h0;
        rst_n                <= 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.sample         <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.window_length <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset window
        foreach (opening[i])
        begin
            send_sample(opening[i]);
        end
        // window of one passes samples straight through
        write_window(7'd1);
        send_sample(32'h0000_0000);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h1234_5678);
        // zero length behaves as one
        write_window(7'd0);
        send_sample(32'hAAAA_AAAA);
        send_sample(32'h5555_5555);

        // random phases: corner lengths first, then half small and half
        // anywhere in the register range
        while (sent < RANDOM_ITEMS)
        begin
            if (phase < 8)
            begin
                win = corner_lens[phase];
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                win = 7'($urandom_range(1, 9));
            end
            else
            begin
                win = 7'($urandom_range(0, 127));
            end
            phase++;
            write_window(win);
            span_len = (win == 0) ? 1 :
                       (win > swm_pkg::WINDOW_MAX_DEF) ? swm_pkg::WINDOW_MAX_DEF : win;
            // enough samples to fill the window and then slide it a while
            phase_items = span_len + $urandom_range(10, 100);
            repeat (phase_items)
            begin
                send_sample(pick_sample());
                sent++;
            end
        end

        settle();
        repeat (6) @(posedge clk);
        if (mismatches == 0 && medians_due == 0)
        begin
            $display("tb_sliding_window_median: clean");
        end
        else
        begin
            $display("tb_sliding_window_median: errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/swm_pkg.sv
sv/swm_if.sv
sv/swm_cell.sv
sv/sliding_window_median.sv
dv/swm_median_checker.sv
dv/tb_sliding_window_median.sv
